FILE: hw/rtl/som_mesh_node_trainer_core_assert.svh
// Assertion macros shared by the checker of the map trainer core.
`ifndef SOM_MESH_NODE_TRAINER_CORE_ASSERT_SVH
`define SOM_MESH_NODE_TRAINER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOMT_ASSERT_SAME(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("som trainer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SOMT_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("som trainer check failed");

`endif

FILE: hw/rtl/somt_pkg.sv
// Package with shared types, operation codes and the rate table of the map trainer.
`default_nettype none
package somt_pkg;
	localparam int ADDR_MAX_W = 12;
	localparam int OP_W = 5;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
	localparam logic [1:0] CFG_RADIUS_BASE = 2'd1;
	localparam logic [1:0] CFG_LEARN_RATE  = 2'd2;
	localparam logic [1:0] CFG_NO_MATCH    = 2'd3;

	localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
	localparam logic [OP_W-1:0] OP_TAKE       = 5'd1;
	localparam logic [OP_W-1:0] OP_CLR        = 5'd2;
	localparam logic [OP_W-1:0] OP_LOAD       = 5'd3;
	localparam logic [OP_W-1:0] OP_RD_W       = 5'd4;
	localparam logic [OP_W-1:0] OP_TRAIN_INIT = 5'd5;
	localparam logic [OP_W-1:0] OP_SCALE      = 5'd6;
	localparam logic [OP_W-1:0] OP_RD_POS     = 5'd7;
	localparam logic [OP_W-1:0] OP_SQ_LOAD    = 5'd8;
	localparam logic [OP_W-1:0] OP_SQ_STEP    = 5'd9;
	localparam logic [OP_W-1:0] OP_SQRT_INIT  = 5'd10;
	localparam logic [OP_W-1:0] OP_SQRT_STEP  = 5'd11;
	localparam logic [OP_W-1:0] OP_SEARCH_CMP = 5'd12;
	localparam logic [OP_W-1:0] OP_RD_BEST    = 5'd13;
	localparam logic [OP_W-1:0] OP_BEST_CAP   = 5'd14;
	localparam logic [OP_W-1:0] OP_RD_NODE    = 5'd15;
	localparam logic [OP_W-1:0] OP_DIV_INIT   = 5'd16;
	localparam logic [OP_W-1:0] OP_DIV_STEP   = 5'd17;
	localparam logic [OP_W-1:0] OP_COEF       = 5'd18;
	localparam logic [OP_W-1:0] OP_COEF2      = 5'd19;
	localparam logic [OP_W-1:0] OP_AX_MUL     = 5'd20;
	localparam logic [OP_W-1:0] OP_AX_ADD     = 5'd21;
	localparam logic [OP_W-1:0] OP_WR_W       = 5'd22;
	localparam logic [OP_W-1:0] OP_OUT_READ   = 5'd23;
	localparam logic [OP_W-1:0] OP_OUT_TRAIN  = 5'd24;

	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [ADDR_MAX_W-1:0] addr;
		logic [1:0]            axis;
		logic [1:0]            part;
		logic                  sel_best;
		logic                  zero;
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
	} dp_sts_t;

	function automatic logic [16:0] rate_rom(input logic [3:0] e);
		logic [16:0] v;
		unique case (e)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd52028;
			4'd2:  v = 17'd45457;
			4'd3:  v = 17'd41304;
			4'd4:  v = 17'd38346;
			4'd5:  v = 17'd36087;
			4'd6:  v = 17'd34282;
			4'd7:  v = 17'd32791;
			4'd8:  v = 17'd31530;
			4'd9:  v = 17'd30442;
			4'd10: v = 17'd29491;
			4'd11: v = 17'd28649;
			4'd12: v = 17'd27896;
			4'd13: v = 17'd27216;
			4'd14: v = 17'd26598;
			4'd15: v = 17'd26032;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/som_mesh_node_trainer_core.sv
// Top level of the self-organizing map trainer core.
//
//   channel   direction   handshake            payload
//   in        to core     in_valid / in_stall  cmd, node_index, coord_x/y/z, epoch
//   out       from core   out_valid/out_stall  result_kind, weight_x/y/z, best_node
//   cfg       to core     cfg_we               cfg_index, cfg_data
//
// A train pass visits the nodes in use twice: a search for the best match, then an update
// of the nodes inside the radius around it; the per-node square root takes 34 steps.
// After reset the weight memory is cleared one entry per cycle over all NODES entries,
// and no input transfer is taken during that pass.
// A stalled result stays in the output register; the next item is taken meanwhile.
`default_nettype none
module som_mesh_node_trainer_core #(
	parameter int NODES  = 256,
	parameter int EPOCHS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [7:0]         node_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [3:0]         epoch,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic signed [31:0] weight_x,
	output logic signed [31:0] weight_y,
	output logic signed [31:0] weight_z,
	output logic [7:0]         best_node,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [39:0]        cfg_data
);
	import somt_pkg::*;

	dp_cmd_t ctl;
	dp_sts_t sts;

	somt_ctrl #(.NODES(NODES)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.node_index     (node_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_node_count (cfg_data[8:0]),
		.ctl            (ctl),
		.sts            (sts)
	);

	somt_dp #(.NODES(NODES), .EPOCHS(EPOCHS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.epoch       (epoch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_kind (result_kind),
		.weight_x    (weight_x),
		.weight_y    (weight_y),
		.weight_z    (weight_z),
		.best_node   (best_node)
	);
endmodule
`default_nettype wire

FILE: hw/rtl/somt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module somt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/somt_dp.sv
// Datapath of the map trainer: node memories, distance, division and weight update.
`default_nettype none
module somt_dp #(
	parameter int NODES  = 256,
	parameter int EPOCHS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  somt_pkg::dp_cmd_t   ctl,
	output somt_pkg::dp_sts_t   sts,
	input  logic signed [31:0]  coord_x,
	input  logic signed [31:0]  coord_y,
	input  logic signed [31:0]  coord_z,
	input  logic [3:0]          epoch,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [39:0]         cfg_data,
	output logic                result_kind,
	output logic signed [31:0]  weight_x,
	output logic signed [31:0]  weight_y,
	output logic signed [31:0]  weight_z,
	output logic [7:0]          best_node
);
	import somt_pkg::*;

	localparam int AW = $clog2(NODES);

	logic [30:0]        radius_base_q;
	logic [15:0]        learn_rate_q;
	logic [39:0]        no_match_q;
	logic signed [31:0] smp_q [3];
	logic [3:0]         epoch_q;
	logic [47:0]        rprod_q;
	logic [32:0]        aprod_q;
	logic [31:0]        radius_q;
	logic [15:0]        alpha_q;
	logic [39:0]        limit_q;
	logic [AW-1:0]      best_q;
	logic signed [31:0] pb_q [3];
	logic signed [31:0] w_q [3];
	logic [32:0]        mag_q [3];
	logic [67:0]        acc_q;
	logic [67:0]        rad_q;
	logic [33:0]        root_q;
	logic [35:0]        srem_q;
	logic [32:0]        drem_q;
	logic [16:0]        dq_q;
	logic [32:0]        cprod_q;
	logic [15:0]        coef_q;
	logic               neg_q;
	logic [48:0]        amul_q;
	logic               kind_q;
	logic signed [31:0] ow_q [3];
	logic [7:0]         ob_q;

	logic [AW-1:0]      addr;
	logic [3:0]         e_lim;
	logic [16:0]        rom;
	logic [95:0]        pos_rdata;
	logic [95:0]        w_rdata;
	logic               pos_re;
	logic               w_re;
	logic               w_we;
	logic [AW-1:0]      pos_raddr;
	logic [95:0]        w_wdata;
	logic signed [31:0] opa;
	logic signed [31:0] opb;
	logic signed [32:0] sq_d [3];
	logic [32:0]        sq_m [3];
	logic [32:0]        m_sel;
	logic [16:0]        mul_x;
	logic [16:0]        mul_y;
	logic [33:0]        pp;
	logic [67:0]        pp_sh;
	logic [37:0]        remx;
	logic [37:0]        trial;
	logic [32:0]        dt;
	logic               rad_zero;
	logic [16:0]        score;
	logic signed [31:0] s_sel;
	logic signed [31:0] w_sel;
	logic signed [32:0] ad;
	logic [32:0]        amag;
	logic [49:0]        qsum;
	logic [31:0]        qv;
	logic signed [31:0] w_new;

	assign addr = ctl.addr[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_base_q <= 31'd589824;
			learn_rate_q  <= 16'd49152;
			no_match_q    <= 40'd6553600000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIUS_BASE: radius_base_q <= cfg_data[30:0];
				CFG_LEARN_RATE:  learn_rate_q  <= cfg_data[15:0];
				CFG_NO_MATCH:    no_match_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(epoch_q) > EPOCHS - 1) begin
			e_lim = 4'(EPOCHS - 1);
		end else begin
			e_lim = epoch_q;
		end
		rom = rate_rom(e_lim);
	end

	assign pos_re    = (ctl.op == OP_RD_POS) || (ctl.op == OP_RD_NODE) || (ctl.op == OP_RD_BEST);
	assign pos_raddr = (ctl.op == OP_RD_BEST) ? best_q : addr;
	assign w_re      = (ctl.op == OP_RD_NODE) || (ctl.op == OP_RD_W);
	assign w_we      = (ctl.op == OP_CLR) || (ctl.op == OP_WR_W);
	assign w_wdata   = (ctl.op == OP_CLR) ? {3{32'h0001_0000}} : {w_q[2], w_q[1], w_q[0]};

	somt_ram #(.WIDTH(96), .DEPTH(NODES)) u_pos_ram (
		.clk     (clk),
		.wr_en   (ctl.op == OP_LOAD),
		.wr_addr (addr),
		.wr_data ({smp_q[2], smp_q[1], smp_q[0]}),
		.rd_en   (pos_re),
		.rd_addr (pos_raddr),
		.rd_data (pos_rdata)
	);

	somt_ram #(.WIDTH(96), .DEPTH(NODES)) u_weight_ram (
		.clk     (clk),
		.wr_en   (w_we),
		.wr_addr (addr),
		.wr_data (w_wdata),
		.rd_en   (w_re),
		.rd_addr (addr),
		.rd_data (w_rdata)
	);

	always_comb begin
		opa = '0;
		opb = '0;
		for (int k = 0; k < 3; k++) begin
			opa = ctl.sel_best ? pb_q[k] : smp_q[k];
			opb = signed'(pos_rdata[32*k +: 32]);
			sq_d[k] = {opa[31], opa} - {opb[31], opb};
			sq_m[k] = sq_d[k][32] ? 33'(-sq_d[k]) : 33'(sq_d[k]);
		end
	end

	always_comb begin
		unique case (ctl.axis)
			2'd1:    m_sel = mag_q[1];
			2'd2:    m_sel = mag_q[2];
			default: m_sel = mag_q[0];
		endcase
		unique case (ctl.part)
			2'd0: begin
				mul_x = m_sel[32:16];
				mul_y = m_sel[32:16];
			end
			2'd1: begin
				mul_x = m_sel[32:16];
				mul_y = {1'b0, m_sel[15:0]};
			end
			default: begin
				mul_x = {1'b0, m_sel[15:0]};
				mul_y = {1'b0, m_sel[15:0]};
			end
		endcase
		pp = 34'(mul_x) * 34'(mul_y);
		unique case (ctl.part)
			2'd0:    pp_sh = 68'({pp, 32'd0});
			2'd1:    pp_sh = 68'({pp, 17'd0});
			2'd2:    pp_sh = 68'(pp);
			default: pp_sh = '0;
		endcase
	end

	assign remx  = {srem_q, rad_q[67:66]};
	assign trial = {2'b00, root_q, 2'b01};
	assign dt    = {drem_q[31:0], 1'b0};
	assign rad_zero = (radius_q == 32'd0);
	assign score = rad_zero ? 17'h1_0000 : 17'h1_0000 - dq_q;
	assign sts.in_range = (root_q <= {2'b00, radius_q});

	always_comb begin
		unique case (ctl.axis)
			2'd1: begin
				s_sel = smp_q[1];
				w_sel = w_q[1];
			end
			2'd2: begin
				s_sel = smp_q[2];
				w_sel = w_q[2];
			end
			default: begin
				s_sel = smp_q[0];
				w_sel = w_q[0];
			end
		endcase
		ad    = {s_sel[31], s_sel} - {w_sel[31], w_sel};
		amag  = ad[32] ? 33'(-ad) : 33'(ad);
		qsum  = {1'b0, amul_q} + 50'd32768;
		qv    = qsum[47:16];
		w_new = neg_q ? w_sel - signed'(qv) : w_sel + signed'(qv);
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_TAKE: begin
				smp_q[0] <= coord_x;
				smp_q[1] <= coord_y;
				smp_q[2] <= coord_z;
				epoch_q  <= epoch;
			end
			OP_TRAIN_INIT: begin
				rprod_q <= 48'(radius_base_q) * 48'(rom);
				aprod_q <= 33'(learn_rate_q) * 33'(rom);
				limit_q <= no_match_q;
				best_q  <= '0;
			end
			OP_SCALE: begin
				radius_q <= 32'((49'(rprod_q) + 49'd32768) >> 16);
				alpha_q  <= 16'((34'(aprod_q) + 34'd32768) >> 16);
			end
			OP_SQ_LOAD: begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= sq_m[k];
					w_q[k]   <= signed'(w_rdata[32*k +: 32]);
				end
				acc_q <= '0;
			end
			OP_SQ_STEP: begin
				acc_q <= acc_q + pp_sh;
			end
			OP_SQRT_INIT: begin
				rad_q  <= acc_q;
				root_q <= '0;
				srem_q <= '0;
			end
			OP_SQRT_STEP: begin
				rad_q <= {rad_q[65:0], 2'b00};
				if (remx >= trial) begin
					srem_q <= 36'(remx - trial);
					root_q <= {root_q[32:0], 1'b1};
				end else begin
					srem_q <= 36'(remx);
					root_q <= {root_q[32:0], 1'b0};
				end
			end
			OP_SEARCH_CMP: begin
				if (40'(root_q) < limit_q) begin
					limit_q <= 40'(root_q);
					best_q  <= addr;
				end
			end
			OP_BEST_CAP: begin
				for (int k = 0; k < 3; k++) begin
					pb_q[k] <= signed'(pos_rdata[32*k +: 32]);
				end
			end
			OP_DIV_INIT: begin
				if (!rad_zero && (root_q >= {2'b00, radius_q})) begin
					drem_q <= 33'(root_q - {2'b00, radius_q});
					dq_q   <= 17'd1;
				end else begin
					drem_q <= 33'(root_q);
					dq_q   <= 17'd0;
				end
			end
			OP_DIV_STEP: begin
				if (dt >= {1'b0, radius_q}) begin
					drem_q <= dt - {1'b0, radius_q};
					dq_q   <= {dq_q[15:0], 1'b1};
				end else begin
					drem_q <= dt;
					dq_q   <= {dq_q[15:0], 1'b0};
				end
			end
			OP_COEF: begin
				cprod_q <= 33'(score) * 33'(alpha_q);
			end
			OP_COEF2: begin
				coef_q <= 16'((34'(cprod_q) + 34'd32768) >> 16);
			end
			OP_AX_MUL: begin
				neg_q  <= ad[32];
				amul_q <= 49'(amag) * 49'(coef_q);
			end
			OP_AX_ADD: begin
				unique case (ctl.axis)
					2'd1:    w_q[1] <= w_new;
					2'd2:    w_q[2] <= w_new;
					default: w_q[0] <= w_new;
				endcase
			end
			OP_OUT_READ: begin
				kind_q <= 1'b0;
				ob_q   <= 8'd0;
				for (int k = 0; k < 3; k++) begin
					ow_q[k] <= ctl.zero ? 32'sd0 : signed'(w_rdata[32*k +: 32]);
				end
			end
			OP_OUT_TRAIN: begin
				kind_q <= 1'b1;
				ob_q   <= 8'(best_q);
				for (int k = 0; k < 3; k++) begin
					ow_q[k] <= 32'sd0;
				end
			end
			default: ;
		endcase
	end

	assign result_kind = kind_q;
	assign weight_x    = ow_q[0];
	assign weight_y    = ow_q[1];
	assign weight_z    = ow_q[2];
	assign best_node   = ob_q;
endmodule
`default_nettype wire

FILE: hw/rtl/somt_ctrl.sv
// Controller state machine that sequences the trainer datapath.
`default_nettype none
module somt_ctrl #(
	parameter int NODES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [7:0]        node_index,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [8:0]        cfg_node_count,
	output somt_pkg::dp_cmd_t ctl,
	input  somt_pkg::dp_sts_t sts
);
	import somt_pkg::*;

	localparam int CW = $clog2(NODES + 1);

	localparam logic [4:0] S_CLEAR     = 5'd0;
	localparam logic [4:0] S_IDLE      = 5'd1;
	localparam logic [4:0] S_DISPATCH  = 5'd2;
	localparam logic [4:0] S_SCALE     = 5'd3;
	localparam logic [4:0] S_RD        = 5'd4;
	localparam logic [4:0] S_SQ_LOAD   = 5'd5;
	localparam logic [4:0] S_SQ        = 5'd6;
	localparam logic [4:0] S_SQRT_INIT = 5'd7;
	localparam logic [4:0] S_SQRT      = 5'd8;
	localparam logic [4:0] S_CMP       = 5'd9;
	localparam logic [4:0] S_BEST_RD   = 5'd10;
	localparam logic [4:0] S_BEST_CAP  = 5'd11;
	localparam logic [4:0] S_DIV_INIT  = 5'd12;
	localparam logic [4:0] S_DIV       = 5'd13;
	localparam logic [4:0] S_COEF      = 5'd14;
	localparam logic [4:0] S_COEF2     = 5'd15;
	localparam logic [4:0] S_AX_MUL    = 5'd16;
	localparam logic [4:0] S_AX_ADD    = 5'd17;
	localparam logic [4:0] S_WR        = 5'd18;
	localparam logic [4:0] S_NEXT      = 5'd19;
	localparam logic [4:0] S_OUT       = 5'd20;

	logic [4:0]    state_q;
	logic [CW-1:0] node_q;
	logic [5:0]    step_q;
	logic [1:0]    axis_q;
	logic [1:0]    part_q;
	logic          upd_q;
	logic [1:0]    cmd_q;
	logic [7:0]    idx_q;
	logic          idx_ok_q;
	logic [8:0]    node_count_q;
	logic          out_valid_q;

	logic          accept;
	logic          out_free;
	logic [CW-1:0] n_use;
	logic          node_last;
	logic          clear_last;

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign n_use      = (32'(node_count_q) > NODES) ? CW'(NODES) : CW'(node_count_q);
	assign node_last  = ((node_q + CW'(1)) == n_use);
	assign clear_last = (node_q == CW'(NODES - 1));

	always_comb begin
		ctl          = '0;
		ctl.op       = OP_NONE;
		ctl.addr     = ADDR_MAX_W'(node_q);
		ctl.axis     = axis_q;
		ctl.part     = part_q;
		ctl.sel_best = upd_q;
		ctl.zero     = !idx_ok_q;
		unique case (state_q)
			S_CLEAR:     ctl.op = OP_CLR;
			S_IDLE:      ctl.op = accept ? OP_TAKE : OP_NONE;
			S_DISPATCH: begin
				ctl.addr = ADDR_MAX_W'(idx_q);
				unique case (cmd_q)
					CMD_LOAD:  ctl.op = idx_ok_q ? OP_LOAD : OP_NONE;
					CMD_READ:  ctl.op = OP_RD_W;
					CMD_TRAIN: ctl.op = OP_TRAIN_INIT;
					default:   ctl.op = OP_NONE;
				endcase
			end
			S_SCALE:     ctl.op = OP_SCALE;
			S_RD:        ctl.op = upd_q ? OP_RD_NODE : OP_RD_POS;
			S_SQ_LOAD:   ctl.op = OP_SQ_LOAD;
			S_SQ:        ctl.op = OP_SQ_STEP;
			S_SQRT_INIT: ctl.op = OP_SQRT_INIT;
			S_SQRT:      ctl.op = OP_SQRT_STEP;
			S_CMP:       ctl.op = OP_SEARCH_CMP;
			S_BEST_RD:   ctl.op = OP_RD_BEST;
			S_BEST_CAP:  ctl.op = OP_BEST_CAP;
			S_DIV_INIT:  ctl.op = OP_DIV_INIT;
			S_DIV:       ctl.op = OP_DIV_STEP;
			S_COEF:      ctl.op = OP_COEF;
			S_COEF2:     ctl.op = OP_COEF2;
			S_AX_MUL:    ctl.op = OP_AX_MUL;
			S_AX_ADD:    ctl.op = OP_AX_ADD;
			S_WR:        ctl.op = OP_WR_W;
			S_NEXT:      ctl.op = OP_NONE;
			S_OUT: begin
				if (out_free) begin
					ctl.op = (cmd_q == CMD_READ) ? OP_OUT_READ : OP_OUT_TRAIN;
				end
			end
			default:     ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 9'd256;
		end else if (cfg_we && (cfg_index == CFG_NODE_COUNT)) begin
			node_count_q <= cfg_node_count;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			idx_q    <= node_index;
			idx_ok_q <= (32'(node_index) < NODES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			node_q      <= '0;
			step_q      <= '0;
			axis_q      <= '0;
			part_q      <= '0;
			upd_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clear_last) begin
						node_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						node_q <= node_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (cmd_q)
						CMD_READ:  state_q <= S_OUT;
						CMD_TRAIN: state_q <= S_SCALE;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_SCALE: begin
					node_q  <= '0;
					upd_q   <= 1'b0;
					state_q <= (n_use == '0) ? S_BEST_RD : S_RD;
				end
				S_RD: state_q <= S_SQ_LOAD;
				S_SQ_LOAD: begin
					axis_q  <= '0;
					part_q  <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (part_q == 2'd2) begin
						part_q <= '0;
						axis_q <= axis_q + 2'd1;
						if (axis_q == 2'd2) begin
							state_q <= S_SQRT_INIT;
						end
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				S_SQRT_INIT: begin
					step_q  <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd33) begin
						state_q <= upd_q ? S_DIV_INIT : S_CMP;
					end
				end
				S_CMP: begin
					if (node_last) begin
						state_q <= S_BEST_RD;
					end else begin
						node_q  <= node_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_BEST_RD: state_q <= S_BEST_CAP;
				S_BEST_CAP: begin
					node_q  <= '0;
					upd_q   <= 1'b1;
					state_q <= (n_use == '0) ? S_OUT : S_RD;
				end
				S_DIV_INIT: begin
					step_q  <= '0;
					state_q <= sts.in_range ? S_DIV : S_NEXT;
				end
				S_DIV: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd15) begin
						state_q <= S_COEF;
					end
				end
				S_COEF:  state_q <= S_COEF2;
				S_COEF2: begin
					axis_q  <= '0;
					state_q <= S_AX_MUL;
				end
				S_AX_MUL: state_q <= S_AX_ADD;
				S_AX_ADD: begin
					if (axis_q == 2'd2) begin
						state_q <= S_WR;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_AX_MUL;
					end
				end
				S_WR: state_q <= S_NEXT;
				S_NEXT: begin
					if (node_last) begin
						state_q <= S_OUT;
					end else begin
						node_q  <= node_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/somt_checker.sv
// Port-level checker of the map trainer core and its bind to the top level.
`default_nettype none
`include "som_mesh_node_trainer_core_assert.svh"
module somt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         cmd,
	input logic [7:0]         node_index,
	input logic signed [31:0] coord_x,
	input logic signed [31:0] coord_y,
	input logic signed [31:0] coord_z,
	input logic [3:0]         epoch,
	input logic               out_valid,
	input logic               out_stall,
	input logic               result_kind,
	input logic signed [31:0] weight_x,
	input logic signed [31:0] weight_y,
	input logic signed [31:0] weight_z,
	input logic [7:0]         best_node,
	input logic               cfg_we,
	input logic [1:0]         cfg_index,
	input logic [39:0]        cfg_data
);
	`SOMT_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
	`SOMT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_kind) && $stable(weight_x) && $stable(weight_y) && $stable(weight_z) && $stable(best_node))
	`SOMT_ASSERT_SAME(a_readout_no_best, out_valid && !result_kind, best_node == 8'd0)
	`SOMT_ASSERT_SAME(a_train_no_weights, out_valid && result_kind, (weight_x == 32'sd0) && (weight_y == 32'sd0) && (weight_z == 32'sd0))
endmodule

bind som_mesh_node_trainer_core somt_checker u_somt_checker (.*);
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the self-organizing map trainer core, with a predictor, input idling and output stalls.
`timescale 1ns / 100ps
module tb_top;
	import somt_pkg::*;

	localparam int         MAP_NODES = 256;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef longint vec3_t[3];

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  node_index;
		logic [31:0] x, y, z;
		logic [3:0]  epoch;
	} som_req_t;

	typedef struct {
		logic        kind;
		logic [31:0] wx, wy, wz;
		logic [7:0]  best;
	} som_rsp_t;

	const int unsigned RATE_TABLE[16] = '{65536, 52028, 45457, 41304, 38346, 36087, 34282,
		32791, 31530, 30442, 29491, 28649, 27896, 27216, 26598, 26032};

	class som_scoreboard;
		longint            pos[MAP_NODES][3];
		longint            wt[MAP_NODES][3];
		longint unsigned   n_nodes, rad_base, lr_base, miss_limit;
		som_rsp_t          pending[$];
		int                errors, n_load, n_train, n_read, n_checked;

		function new();
			n_nodes = 256;
			rad_base = 589824;
			lr_base = 49152;
			miss_limit = 64'd6553600000;
			foreach (pos[i, k]) begin
				pos[i][k] = 0;
				wt[i][k] = 65536;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [39:0] data);
			case (idx)
				CFG_NODE_COUNT:  n_nodes = data[8:0];
				CFG_RADIUS_BASE: rad_base = data[30:0];
				CFG_LEARN_RATE:  lr_base = data[15:0];
				CFG_NO_MATCH:    miss_limit = data;
				default:         ;
			endcase
		endfunction

		function void queue_rsp(som_rsp_t rs);
			pending = {pending, rs};
		endfunction

		function longint unsigned node_dist(vec3_t a, vec3_t b);
			bit [71:0] acc, r, t, m;
			longint    d;
			acc = 0;
			r = 0;
			for (int k = 0; k < 3; k++) begin
				d = a[k] - b[k];
				m = d < 0 ? 72'(-d) : 72'(d);
				acc += m * m;
			end
			for (int k = 34; k >= 0; k--) begin
				t = r | (72'd1 << k);
				if (t * t <= acc)
					r = t;
			end
			return r[63:0];
		endfunction

		function void note_transfer(som_req_t rq);
			vec3_t           smp, pa, pb;
			longint unsigned n, rom, radius, alpha, lim, d, score, coef, mag, q;
			longint          diff;
			int              best;
			som_rsp_t        rs;
			smp[0] = longint'($signed(rq.x));
			smp[1] = longint'($signed(rq.y));
			smp[2] = longint'($signed(rq.z));
			rs = '{default: '0};
			case (rq.cmd)
				CMD_LOAD: begin
					n_load++;
					for (int k = 0; k < 3; k++)
						pos[rq.node_index][k] = smp[k];
				end
				CMD_READ: begin
					n_read++;
					rs.kind = 1'b0;
					rs.wx = wt[rq.node_index][0][31:0];
					rs.wy = wt[rq.node_index][1][31:0];
					rs.wz = wt[rq.node_index][2][31:0];
					queue_rsp(rs);
				end
				CMD_TRAIN: begin
					n_train++;
					n = n_nodes > MAP_NODES ? MAP_NODES : n_nodes;
					rom = RATE_TABLE[rq.epoch];
					radius = (rad_base * rom + 32768) >> 16;
					alpha = (lr_base * rom + 32768) >> 16;
					lim = miss_limit;
					best = 0;
					for (int i = 0; i < n; i++) begin
						pa = pos[i];
						d = node_dist(smp, pa);
						if (d < lim) begin
							lim = d;
							best = i;
						end
					end
					pb = pos[best];
					for (int i = 0; i < n; i++) begin
						pa = pos[i];
						d = node_dist(pa, pb);
						if (d <= radius) begin
							score = radius == 0 ? 65536 : 65536 - (d << 16) / radius;
							coef = (score * alpha + 32768) >> 16;
							for (int k = 0; k < 3; k++) begin
								diff = smp[k] - wt[i][k];
								mag = diff < 0 ? -diff : diff;
								q = (mag * coef + 32768) >> 16;
								wt[i][k] = diff < 0 ? wt[i][k] - longint'(q) : wt[i][k] + longint'(q);
							end
						end
					end
					rs.kind = 1'b1;
					rs.best = best[7:0];
					queue_rsp(rs);
				end
				default: ;
			endcase
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch on %s: got %h, expected %h", what, got, want);
			errors++;
		endtask

		task check_result(som_rsp_t got);
			som_rsp_t want;
			if (pending.size() == 0) begin
				$display("result transfer with nothing outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			n_checked++;
			if (got.kind !== want.kind) report("result_kind", got.kind, want.kind);
			if (got.wx !== want.wx) report("weight_x", got.wx, want.wx);
			if (got.wy !== want.wy) report("weight_y", got.wy, want.wy);
			if (got.wz !== want.wz) report("weight_z", got.wz, want.wz);
			if (got.best !== want.best) report("best_node", got.best, want.best);
		endtask
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [1:0]  cmd;
	logic [7:0]  node_index;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic [3:0]  epoch;
	logic        result_kind;
	logic signed [31:0] weight_x, weight_y, weight_z;
	logic [7:0]  best_node;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [39:0] cfg_data;

	som_scoreboard sb = new();
	int            send_idle_pct, recv_stall_pct;

	som_mesh_node_trainer_core u_dut (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{result_kind, weight_x, weight_y, weight_z, best_node});
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task send(som_req_t rq);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= rq.cmd;
		node_index <= rq.node_index;
		coord_x <= rq.x;
		coord_y <= rq.y;
		coord_z <= rq.z;
		epoch <= rq.epoch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_transfer(rq);
	endtask

	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task cfg_write(logic [1:0] idx, logic [39:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task set_regs(logic [8:0] cnt, logic [30:0] rad, logic [15:0] lr, logic [39:0] lim);
		cfg_write(CFG_NODE_COUNT, 40'(cnt));
		cfg_write(CFG_RADIUS_BASE, 40'(rad));
		cfg_write(CFG_LEARN_RATE, 40'(lr));
		cfg_write(CFG_NO_MATCH, lim);
		cfg_we <= 1'b0;
	endtask

	function logic [31:0] rand_coord();
		if ($urandom_range(9) == 0)
			return $urandom();
		return 32'($signed($urandom_range(2097152)) - 1048576);
	endfunction

	function som_req_t rand_req();
		som_req_t    rq;
		int unsigned p;
		p = $urandom_range(99);
		rq.cmd = p < 40 ? CMD_TRAIN : p < 65 ? CMD_READ : p < 90 ? CMD_LOAD : CMD_UNUSED;
		rq.node_index = $urandom_range(255);
		if (rq.cmd == CMD_TRAIN || rq.cmd == CMD_LOAD)
			rq.node_index = $urandom_range(7) == 0 ? rq.node_index : $urandom_range(15);
		rq.x = rand_coord();
		rq.y = rand_coord();
		rq.z = rand_coord();
		rq.epoch = $urandom_range(15);
		return rq;
	endfunction

	task run_random(int count);
		for (int i = 0; i < count; i++)
			send(rand_req());
	endtask

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		node_index = '0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		epoch = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_NODE_COUNT;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs(9'd16, 31'd589824, 16'd49152, 40'd6553600000);

		// Every position is written before any training pass reads it.
		for (int i = 0; i < MAP_NODES; i++)
			send('{CMD_LOAD, 8'(i), rand_coord(), rand_coord(), rand_coord(), 4'd0});

		send('{CMD_READ, 8'd0, 32'd0, 32'd0, 32'd0, 4'd0});
		send('{CMD_READ, 8'd255, 32'd0, 32'd0, 32'd0, 4'd0});
		send('{CMD_LOAD, 8'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 4'd0});
		send('{CMD_LOAD, 8'd2, 32'h80000000, 32'h80000000, 32'h80000000, 4'd0});
		send('{CMD_LOAD, 8'd255, 32'hffffffff, 32'h00000001, 32'h55555555, 4'd15});
		send('{CMD_TRAIN, 8'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 4'd0});
		send('{CMD_TRAIN, 8'd0, 32'h80000000, 32'h80000000, 32'h80000000, 4'd15});
		send('{CMD_TRAIN, 8'd255, 32'h00010000, 32'h00010000, 32'h00010000, 4'd7});
		send('{CMD_UNUSED, 8'd3, 32'hdeadbeef, 32'h0, 32'h0, 4'd9});
		send('{CMD_READ, 8'd1, 32'h0, 32'h0, 32'h0, 4'd0});
		send('{CMD_READ, 8'd2, 32'h0, 32'h0, 32'h0, 4'd0});
		send('{CMD_READ, 8'd255, 32'h0, 32'h0, 32'h0, 4'd0});
		run_random(30);
		drain();

		set_regs(9'd1, 31'd0, 16'd65535, 40'hff_ffff_ffff);
		send_idle_pct = 60;
		run_random(20);
		drain();
		run_random(20);
		drain();

		set_regs(9'd40, 31'h7fffffff, 16'd0, 40'd0);
		send_idle_pct = 0;
		recv_stall_pct = 60;
		run_random(30);
		drain();

		set_regs(9'd8, 31'd131072, 16'd30000, 40'd6553600000);
		send_idle_pct = 10;
		recv_stall_pct = 10;
		run_random(30);
		drain();

		set_regs(9'd0, 31'd589824, 16'd49152, 40'd6553600000);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(10);
		drain();

		set_regs(9'd511, 31'd589824, 16'd49152, 40'd6553600000);
		run_random(5);
		drain();

		set_regs(9'd256, 31'd1000000, 16'd20000, 40'd6553600000);
		run_random(5);
		drain();

		$display("covered %0d loads, %0d training steps and %0d reads; %0d results checked",
			sb.n_load, sb.n_train, sb.n_read, sb.n_checked);
		$display("register sweep included zero and full node counts and extreme rates");
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
